// File: sv/skvt_pkg.sv
package skvt_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] MODE_FIND   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [8:0]  position;
      logic [8:0]  count_after;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic           load;      // capture request
      logic           srch_init;
      logic           rd_mid;    // issue read at midpoint
      logic           srch_step; // compare the returned key
      logic           fix_pos;   // settle insertion point
      logic           rd_shift;  // read entry for shifting
      logic           wr_shift;  // write entry read last cycle
      logic           wr_new;    // write the new entry
      logic           rd_val;    // read value at position
      logic           cnt_inc;
      logic           cnt_dec;
      logic           build;     // form the result
      logic [1:0]     status;
      logic           use_data;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic srch_done;
      logic hit;
      logic shift_done;  // no more entries to move
   } sts_type;

endpackage

// File: sv/skvt_ctrl.sv
module skvt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         mode,
   input  skvt_pkg::sts_type  sts,
   output skvt_pkg::ctl_type  ctl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_CMP    = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_SHRD   = 4'd5;
   localparam logic [3:0] S_SHWR   = 4'd6;
   localparam logic [3:0] S_WRNEW  = 4'd7;
   localparam logic [3:0] S_VRD    = 4'd8;
   localparam logic [3:0] S_VWAIT  = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.load = 1'b1;
               mode_in  = mode;
               state_in = S_START;
            end
         end
         S_START: begin
            priority if (mode_ff == skvt_pkg::MODE_FIND && sts.empty) begin
               ctl.status = skvt_pkg::ST_NOTFOUND;
               state_in   = S_OUT;
            end else if (mode_ff == skvt_pkg::MODE_INSERT && sts.full) begin
               ctl.status = skvt_pkg::ST_FULL;
               state_in   = S_OUT;
            end else if (mode_ff == skvt_pkg::MODE_DELETE && sts.empty) begin
               ctl.status = skvt_pkg::ST_EMPTY;
               state_in   = S_OUT;
            end else if (mode_ff == skvt_pkg::MODE_NONE) begin
               state_in = S_OUT;
            end else begin
               ctl.srch_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            if (sts.srch_done) begin
               ctl.fix_pos = 1'b1;
               state_in    = S_DECIDE;
            end else begin
               ctl.rd_mid = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            ctl.srch_step = 1'b1;
            state_in      = S_RD;
         end
         S_DECIDE: begin
            unique case (mode_ff)
               skvt_pkg::MODE_FIND: begin
                  if (sts.hit) state_in = S_VRD;
                  else begin
                     ctl.status = skvt_pkg::ST_NOTFOUND;
                     state_in   = S_OUT;
                  end
               end
               skvt_pkg::MODE_INSERT: state_in = S_SHRD;
               default: begin
                  if (sts.hit) state_in = S_SHRD;
                  else begin
                     ctl.status = skvt_pkg::ST_NOTFOUND;
                     state_in   = S_OUT;
                  end
               end
            endcase
         end
         S_SHRD: begin
            if (sts.shift_done) begin
               if (mode_ff == skvt_pkg::MODE_INSERT) state_in = S_WRNEW;
               else begin
                  ctl.cnt_dec = 1'b1;
                  state_in    = S_OUT;
               end
            end else begin
               ctl.rd_shift = 1'b1;
               state_in     = S_SHWR;
            end
         end
         S_SHWR: begin
            ctl.wr_shift = 1'b1;
            state_in     = S_SHRD;
         end
         S_WRNEW: begin
            ctl.wr_new  = 1'b1;
            ctl.cnt_inc = 1'b1;
            state_in    = S_OUT;
         end
         S_VRD: begin
            ctl.rd_val = 1'b1;
            state_in   = S_VWAIT;
         end
         S_VWAIT: begin
            ctl.use_data = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.build    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response not from output state");
   a_shift_pair: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_shift |=> ctl.wr_shift)
      else $error("shift read without write");
`endif

endmodule

// File: sv/skvt_dp.sv
module skvt_dp (
   input  logic               clock,
   input  logic               reset,
   input  skvt_pkg::req_type  req,
   input  skvt_pkg::ctl_type  ctl,
   output skvt_pkg::sts_type  sts,
   output skvt_pkg::rsp_type  rsp
);

   localparam int IW = skvt_pkg::IDX_W;
   localparam int CW = skvt_pkg::CNT_W;
   // search bounds carry one extra bit for the signed -1 case
   localparam int BW = CW + 1;

   logic [31:0] key_mem [skvt_pkg::DEPTH];
   logic [31:0] val_mem [skvt_pkg::DEPTH];

   logic [1:0]    mode_ff;
   logic [31:0]   key_ff, value_ff;
   logic [CW-1:0] count_ff;
   logic [BW-1:0] left_ff, right_ff;
   logic [CW-1:0] mid_ff, pos_ff, sh_ff;
   logic          hit_ff, done_ff, valid_ff;
   logic [31:0]   rk_ff, rv_ff;
   logic [1:0]    status_ff;
   logic [31:0]   data_ff;
   skvt_pkg::rsp_type rsp_ff;

   logic [BW-1:0] mid_c;
   logic [IW-1:0] rd_addr;
   logic          rd_en, is_ins;
   logic [CW-1:0] sh_src, sh_dst;

   assign is_ins = (mode_ff == skvt_pkg::MODE_INSERT);
   assign mid_c  = left_ff + ((right_ff - left_ff) >> 1);

   // insert moves i-1 -> i downwards from count; delete moves i+1 -> i upwards
   assign sh_src = is_ins ? sh_ff - CW'(1) : sh_ff + CW'(1);
   assign sh_dst = sh_ff;

   always_comb begin
      rd_en   = ctl.rd_mid | ctl.rd_shift | ctl.rd_val;
      rd_addr = '0;
      priority if (ctl.rd_mid) rd_addr = mid_c[IW-1:0];
      else if (ctl.rd_shift) rd_addr = sh_src[IW-1:0];
      else rd_addr = pos_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rk_ff <= key_mem[rd_addr];
         rv_ff <= val_mem[rd_addr];
      end
      if (ctl.wr_shift) begin
         key_mem[sh_dst[IW-1:0]] <= rk_ff;
         val_mem[sh_dst[IW-1:0]] <= rv_ff;
      end else if (ctl.wr_new) begin
         key_mem[pos_ff[IW-1:0]] <= key_ff;
         val_mem[pos_ff[IW-1:0]] <= value_ff;
      end
   end

   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff >= CW'(skvt_pkg::DEPTH));
   assign sts.srch_done  = done_ff || $signed(left_ff) > $signed(right_ff);
   assign sts.hit        = hit_ff;
   assign sts.shift_done = is_ins ? (sh_ff <= pos_ff) : (sh_src >= count_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff  <= req.mode;
         key_ff   <= req.key;
         value_ff <= req.value;
         status_ff <= skvt_pkg::ST_OK;
         data_ff   <= '0;
         pos_ff    <= '0;
      end
      if (ctl.srch_init) begin
         left_ff  <= '0;
         right_ff <= BW'(count_ff) - BW'(1);
         hit_ff   <= 1'b0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
         mid_ff   <= '0;
      end
      if (ctl.rd_mid) mid_ff <= mid_c[CW-1:0];
      if (ctl.srch_step) begin
         valid_ff <= 1'b1;
         if (rk_ff == key_ff) begin
            hit_ff  <= 1'b1;
            done_ff <= 1'b1;
         end else if (rk_ff < key_ff) left_ff <= BW'(mid_ff) + BW'(1);
         else right_ff <= BW'(mid_ff) - BW'(1);
      end
      if (ctl.fix_pos) begin
         // rk_ff still holds the key of the last midpoint
         if (!hit_ff && valid_ff && rk_ff < key_ff) pos_ff <= mid_ff + CW'(1);
         else pos_ff <= mid_ff;
         sh_ff <= is_ins ? count_ff : mid_ff;
      end
      if (ctl.wr_shift) sh_ff <= is_ins ? sh_ff - CW'(1) : sh_ff + CW'(1);
      if (ctl.status != skvt_pkg::ST_OK) status_ff <= ctl.status;
      if (ctl.use_data) data_ff <= rv_ff;
      if (ctl.build) begin
         rsp_ff.status      <= (ctl.status != skvt_pkg::ST_OK) ? ctl.status : status_ff;
         rsp_ff.data_out    <= data_ff;
         rsp_ff.position    <= 9'(pos_ff);
         rsp_ff.count_after <= 9'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (ctl.cnt_inc) count_ff <= count_ff + CW'(1);
      else if (ctl.cnt_dec) count_ff <= count_ff - CW'(1);
   end

   assign rsp = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(skvt_pkg::DEPTH))
      else $error("count beyond depth");
   a_no_inc_full: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_inc |-> !sts.full)
      else $error("insert into full table");
   a_no_dec_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_dec |-> !sts.empty)
      else $error("delete from empty table");
`endif

endmodule

// File: sv/sorted_key_value_table.sv
// Sorted key-value table of skvt_pkg::DEPTH entries kept in ascending unsigned key order,
// duplicates allowed. One request at a time: find, insert or delete, one response each.
// The binary search makes at most log2(DEPTH)+1 probes, each one read of the single-port key
// memory; insert and delete then move each shifted entry by a read and then a write through
// the same port, before the result is formed and offered. The next request can be taken in
// the cycle the response is offered, provided rsp_ready accepts the response in that cycle.
module sorted_key_value_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  skvt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output skvt_pkg::rsp_type  rsp_data
);

   skvt_pkg::ctl_type ctl;
   skvt_pkg::sts_type sts;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .mode      (req_data.mode),
      .sts       (sts),
      .ctl       (ctl)
   );

   skvt_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .ctl   (ctl),
      .sts   (sts),
      .rsp   (rsp_data)
   );

endmodule
